FILE: rtl/rotating_ring_range_sum_defines.svh
// ----------------------------------------------------------------------------
// rotating_ring_range_sum_defines.svh
// assertion macros shared by the ring range sum block
// ----------------------------------------------------------------------------
`ifndef ROTATING_RING_RANGE_SUM_DEFINES_SVH
`define ROTATING_RING_RANGE_SUM_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RRRS_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RRRS_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rrrs_pkg.sv
// ----------------------------------------------------------------------------
// rrrs_pkg
// types and fixed constants of the rotating ring range sum block
// ----------------------------------------------------------------------------
`default_nettype none

package rrrs_pkg;

  localparam int SUM_W     = 42;
  localparam int CFG_W     = 11;
  localparam int VAL_IN_W  = 32;
  localparam int POS_W     = 11;
  localparam int OP_W      = 2;
  localparam int CFG_RESET = 1024;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ROTATE,
    CMD_QUERY
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROT,
    BK_QHI,
    BK_QLO,
    BK_QOUT
  } bk_state_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [VAL_IN_W-1:0] element_value;
    logic [VAL_IN_W-1:0] shift_amount;
    logic [POS_W-1:0]    range_first;
    logic [POS_W-1:0]    range_last;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] range_sum;
    logic             range_error;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                bounds_bad;
    logic [VAL_IN_W-1:0] value;
    logic [VAL_IN_W-1:0] shift;
    logic [POS_W-1:0]    first;
    logic [POS_W-1:0]    last;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/rotating_ring_range_sum.sv
// ----------------------------------------------------------------------------
// rotating_ring_range_sum
// ring of values held as prefix sums, with rotation and range sum queries
//
// a command is taken on a clock edge with start high and busy low; its
// in_item carries the operation: load appends a value, rotate advances the
// start offset by shift_amount modulo the element count, query returns the
// sum of range_first..range_last of the rotated ring. unknown operations
// are dropped. commands pass through a two-entry queue; busy is high while
// it is full. the execution unit takes a command only once done with the
// last; a rotate waits on the bit-serial remainder unit (one dividend bit a
// cycle) and a query reads the upper, then the lower prefix through the one
// read port of the prefix memory, then subtracts. a query result shows on
// out_item for one cycle with out_strobe high; bad bounds or a ring not
// fully loaded give range_error with a zero sum, sent without the reads.
// the receiver cannot stall the result. cfg_we writes the element count
// and empties the ring; write it only with no command outstanding.
// reset sets the count to 1024 (or the ring depth if smaller) and empties
// the ring; the prefix memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotating_ring_range_sum_defines.svh"

module rotating_ring_range_sum import rrrs_pkg::*; #(
  parameter int RING_DEPTH = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RST_CNT = (RING_DEPTH < CFG_RESET) ? RING_DEPTH : CFG_RESET;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CMP_W-1:0] wdata_ext;

  logic q_push;
  cmd_t f_cmd;
  cmd_t q_head;
  logic q_not_empty;
  logic q_full;
  logic bk_pop;
  logic ring_full;

  // element count is held already clamped to 1..RING_DEPTH
  assign wdata_ext = CMP_W'(cfg_wdata);

  always_comb begin
    if (wdata_ext == '0) begin
      count_nxt = CNT_W'(1);
    end else if (wdata_ext > CMP_W'(RING_DEPTH)) begin
      count_nxt = CNT_W'(RING_DEPTH);
    end else begin
      count_nxt = CNT_W'(wdata_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(RST_CNT);
    end else if (cfg_we) begin
      count_r <= count_nxt;
    end
  end

  assign busy = q_full;

  rrrs_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .start   (start),
    .busy    (q_full),
    .in_item (in_item),
    .count   (count_r),
    .push    (q_push),
    .cmd     (f_cmd)
  );

  rrrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .cmd       (f_cmd),
    .pop       (bk_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  rrrs_back #(
    .RING_DEPTH (RING_DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .count      (count_r),
    .clear      (cfg_we),
    .head       (q_head),
    .head_valid (q_not_empty),
    .pop        (bk_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .ring_full  (ring_full)
  );

  `RRRS_ASSERT_IMP(a_err_zero_sum, clk, rst_n, out_strobe && out_item.range_error, out_item.range_sum == '0, "error result with non-zero sum")
  `RRRS_ASSERT_NXT(a_cfg_empties_ring, clk, rst_n, cfg_we, !ring_full, "ring still full after count write")
  `RRRS_ASSERT_IMP(a_busy_after_transfer, clk, rst_n, $rose(busy), $past(start), "queue filled with no transfer in")

endmodule

`default_nettype wire

FILE: rtl/rrrs_front.sv
// ----------------------------------------------------------------------------
// rrrs_front
// accepts commands, drops unknown operations and pre-checks query bounds
// ----------------------------------------------------------------------------
`default_nettype none

module rrrs_front import rrrs_pkg::*; #(
  parameter int CNT_W = 11
) (
  input  wire logic             start,
  input  wire logic             busy,
  input  wire in_item_t         in_item,
  input  wire logic [CNT_W-1:0] count,
  output logic                  push,
  output cmd_t                  cmd
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CMP_W-1:0] last_ext;
  logic [CMP_W-1:0] count_ext;

  assign last_ext  = CMP_W'(in_item.range_last);
  assign count_ext = CMP_W'(count);

  always_comb begin
    cmd.value      = in_item.element_value;
    cmd.shift      = in_item.shift_amount;
    cmd.first      = in_item.range_first;
    cmd.last       = in_item.range_last;
    cmd.bounds_bad = (in_item.range_first == '0) ||
                     (in_item.range_last < in_item.range_first) ||
                     (last_ext > count_ext);
    cmd.kind       = CMD_LOAD;
    push           = 1'b0;
    case (in_item.operation)
      OP_LOAD: begin
        cmd.kind = CMD_LOAD;
        push     = start && !busy;
      end
      OP_ROTATE: begin
        cmd.kind = CMD_ROTATE;
        push     = start && !busy;
      end
      OP_QUERY: begin
        cmd.kind = CMD_QUERY;
        push     = start && !busy;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/rrrs_queue.sv
// ----------------------------------------------------------------------------
// rrrs_queue
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module rrrs_queue import rrrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      not_empty,
  output logic      full
);

  localparam int QDEPTH = 2;

  cmd_t       ent_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cmd;
    end
  end

  assign head      = ent_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == 2'(QDEPTH));

endmodule

`default_nettype wire

FILE: rtl/rrrs_modunit.sv
// ----------------------------------------------------------------------------
// rrrs_modunit
// bit-serial remainder of a 32-bit shift by the element count
// ----------------------------------------------------------------------------
`default_nettype none

module rrrs_modunit import rrrs_pkg::*; #(
  parameter int IDX_W = 10,
  parameter int CNT_W = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic [VAL_IN_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]    divisor,
  output logic                     done,
  output logic [IDX_W-1:0]         rem
);

  localparam int STEP_W = $clog2(VAL_IN_W);

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [VAL_IN_W-1:0] dvd_r, dvd_nxt;
  logic [IDX_W-1:0]    rem_r, rem_nxt;
  logic [IDX_W:0]      trial;
  logic [IDX_W:0]      dv;

  assign trial = {rem_r, dvd_r[VAL_IN_W-1]};
  assign dv    = (IDX_W+1)'(divisor);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (go) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(VAL_IN_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (run_r) begin
      // restoring step, one dividend bit a cycle
      rem_nxt  = (trial >= dv) ? IDX_W'(trial - dv) : IDX_W'(trial);
      dvd_nxt  = {dvd_r[VAL_IN_W-2:0], 1'b0};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: rtl/rrrs_back.sv
// ----------------------------------------------------------------------------
// rrrs_back
// executes loads, rotations and range queries against the prefix memory
// ----------------------------------------------------------------------------
`default_nettype none

module rrrs_back import rrrs_pkg::*; #(
  parameter int RING_DEPTH = 1024,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 10,
  parameter int CNT_W      = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             clear,
  input  wire cmd_t             head,
  input  wire logic             head_valid,
  output logic                  pop,
  output logic                  out_strobe,
  output out_item_t             out_item,
  output logic                  ring_full
);

  localparam int HW = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam logic [VAL_IN_W-1:0] VMASK =
    (VALUE_BITS >= VAL_IN_W) ? {VAL_IN_W{1'b1}} :
    VAL_IN_W'((64'd1 << VALUE_BITS) - 64'd1);

  bk_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] first_r, first_nxt;
  logic             hi_wrap_r, hi_wrap_nxt;
  logic             lo_zero_r, lo_zero_nxt;
  logic             lo_wrap_r, lo_wrap_nxt;
  logic [SUM_W-1:0] upper_r, upper_nxt;
  logic [SUM_W-1:0] lower_r, lower_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic             out_err_r, out_err_nxt;

  logic [SUM_W-1:0] prefix_mem [RING_DEPTH];
  logic [SUM_W-1:0] rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [SUM_W-1:0] mem_wdata;
  logic [IDX_W-1:0] rd_addr;

  logic             div_go;
  logic             div_done;
  logic [IDX_W-1:0] div_rem;

  logic             q_err;
  logic [SUM_W-1:0] load_sum;
  logic [HW-1:0]    n_hw;
  logic [HW-1:0]    hi_full;
  logic             hi_wrap;
  logic [HW-1:0]    hi_idx;
  logic [HW-1:0]    lo_full;
  logic             lo_wrap;
  logic [HW-1:0]    lo_idx;
  logic [IDX_W:0]   rot_sum;
  logic [IDX_W:0]   rot_n;
  logic [IDX_W:0]   rot_next;

  rrrs_modunit #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_modunit (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (head.shift),
    .divisor  (count),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign ring_full = (loaded_r == count);
  assign q_err     = head.bounds_bad || !ring_full;
  assign load_sum  = total_r + SUM_W'(head.value & VMASK);
  assign n_hw      = HW'(count);

  // upper bound index into the doubled ring, folded back past the end
  assign hi_full = HW'(start_r) + HW'(head.last) - HW'(1);
  assign hi_wrap = (hi_full >= n_hw);
  assign hi_idx  = hi_wrap ? (hi_full - n_hw) : hi_full;

  // prefix just before the lower bound
  assign lo_full = HW'(start_r) + HW'(first_r) - HW'(2);
  assign lo_wrap = (lo_full >= n_hw);
  assign lo_idx  = lo_wrap ? (lo_full - n_hw) : lo_full;

  assign rot_sum  = (IDX_W+1)'(start_r) + (IDX_W+1)'(div_rem);
  assign rot_n    = (IDX_W+1)'(count);
  assign rot_next = (rot_sum >= rot_n) ? (rot_sum - rot_n) : rot_sum;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.kind)
            CMD_ROTATE: state_nxt = BK_ROT;
            CMD_QUERY: begin
              if (!q_err) begin
                state_nxt = BK_QHI;
              end
            end
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_ROT: begin
        if (div_done) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_QHI:  state_nxt = BK_QLO;
      BK_QLO:  state_nxt = BK_QOUT;
      BK_QOUT: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    loaded_nxt    = loaded_r;
    total_nxt     = total_r;
    start_nxt     = start_r;
    first_nxt     = first_r;
    hi_wrap_nxt   = hi_wrap_r;
    lo_zero_nxt   = lo_zero_r;
    lo_wrap_nxt   = lo_wrap_r;
    upper_nxt     = upper_r;
    lower_nxt     = lower_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    wr_addr       = loaded_r[IDX_W-1:0];
    mem_wdata     = load_sum;
    rd_addr       = '0;
    div_go        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          case (head.kind)
            CMD_LOAD: begin
              // a load into a full ring is dropped
              if (!ring_full) begin
                mem_we     = 1'b1;
                total_nxt  = load_sum;
                loaded_nxt = loaded_r + CNT_W'(1);
              end
            end
            CMD_ROTATE: begin
              div_go = 1'b1;
            end
            CMD_QUERY: begin
              if (q_err) begin
                out_valid_nxt = 1'b1;
                out_sum_nxt   = '0;
                out_err_nxt   = 1'b1;
              end else begin
                rd_addr     = hi_idx[IDX_W-1:0];
                hi_wrap_nxt = hi_wrap;
                first_nxt   = head.first;
              end
            end
            default: begin
              div_go = 1'b0;
            end
          endcase
        end
      end
      BK_ROT: begin
        if (div_done) begin
          start_nxt = rot_next[IDX_W-1:0];
        end
      end
      BK_QHI: begin
        upper_nxt   = hi_wrap_r ? (total_r + rd_data_r) : rd_data_r;
        rd_addr     = lo_idx[IDX_W-1:0];
        lo_zero_nxt = (start_r == '0) && (first_r == POS_W'(1));
        lo_wrap_nxt = lo_wrap;
      end
      BK_QLO: begin
        if (lo_zero_r) begin
          lower_nxt = '0;
        end else begin
          lower_nxt = lo_wrap_r ? (total_r + rd_data_r) : rd_data_r;
        end
      end
      BK_QOUT: begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = upper_r - lower_r;
        out_err_nxt   = 1'b0;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      loaded_r    <= '0;
      total_r     <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clear) begin
        loaded_r <= '0;
        total_r  <= '0;
        start_r  <= '0;
      end else begin
        loaded_r <= loaded_nxt;
        total_r  <= total_nxt;
        start_r  <= start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r   <= first_nxt;
    hi_wrap_r <= hi_wrap_nxt;
    lo_zero_r <= lo_zero_nxt;
    lo_wrap_r <= lo_wrap_nxt;
    upper_r   <= upper_nxt;
    lower_r   <= lower_nxt;
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prefix_mem[wr_addr] <= mem_wdata;
    end
    rd_data_r <= prefix_mem[rd_addr];
  end

  assign out_strobe           = out_valid_r;
  assign out_item.range_sum   = out_sum_r;
  assign out_item.range_error = out_err_r;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives load, rotate and range sum commands into the ring range sum block,
// keeps its own copy of the ring and checks every query result in order
// ----------------------------------------------------------------------------
module testbench;
  import rrrs_pkg::*;

  localparam int RING = 1024;
  localparam int SETTLE = 200;
  localparam int STALL_LIMIT = 2000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // in-order model of the ring and the queue of sums it predicts
  class range_sum_board;
    logic [SUM_W-1:0] prefix_mem [RING];
    logic [SUM_W-1:0] total;
    int unsigned offset;
    int unsigned loaded;
    logic [CFG_W-1:0] count_reg;
    out_item_t pending_sums [$];
    int failures;

    function new();
      count_reg = CFG_W'(CFG_RESET);
      total = '0;
      offset = 0;
      loaded = 0;
      failures = 0;
    endfunction

    function void write_count(logic [CFG_W-1:0] v);
      count_reg = v;
      total = '0;
      offset = 0;
      loaded = 0;
    endfunction

    function int unsigned ring_len();
      if (count_reg == 0) return 1;
      if (count_reg > RING) return RING;
      return count_reg;
    endfunction

    // prefix in the doubled ring, pos below twice the length
    function logic [SUM_W-1:0] prefix_of(int unsigned pos, int unsigned n);
      if (pos < n) return prefix_mem[pos];
      return total + prefix_mem[pos - n];
    endfunction

    function void note_command(in_item_t it);
      int unsigned n;
      int unsigned s;
      int unsigned l;
      int unsigned r;
      logic [SUM_W-1:0] upper;
      logic [SUM_W-1:0] lower;
      out_item_t res;
      n = ring_len();
      case (it.operation)
        OP_LOAD: begin
          if (loaded < n) begin
            total = total + {{(SUM_W-VAL_IN_W){1'b0}}, it.element_value};
            prefix_mem[loaded] = total;
            loaded++;
          end
        end
        OP_ROTATE: begin
          offset = (offset % n + it.shift_amount % n) % n;
        end
        OP_QUERY: begin
          l = it.range_first;
          r = it.range_last;
          s = offset % n;
          if (loaded != n || l == 0 || r < l || r > n) begin
            res.range_sum = '0;
            res.range_error = 1'b1;
          end else begin
            upper = prefix_of(s + r - 1, n);
            lower = (s + l - 1 == 0) ? '0 : prefix_of(s + l - 2, n);
            res.range_sum = upper - lower;
            res.range_error = 1'b0;
          end
          pending_sums.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      failures++;
    endtask

    task check_sum(out_item_t got);
      out_item_t want;
      if (pending_sums.size() == 0) begin
        report("result with no query pending");
        return;
      end
      want = pending_sums.pop_front();
      if (got.range_sum !== want.range_sum)
        report($sformatf("range_sum %0h, wanted %0h", got.range_sum, want.range_sum));
      if (got.range_error !== want.range_error)
        report($sformatf("range_error %b, wanted %b", got.range_error, want.range_error));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  range_sum_board board = new();
  bit gaps_on = 1'b1;
  int idle_run = 0;

  always #10 clk = ~clk;

  rotating_ring_range_sum uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_sum(out_item);
  end

  // ends the run when no transfer happens for too long
  initial begin
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) idle_run = 0;
      else idle_run++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [31:0] value,
                                         logic [31:0] shift, logic [POS_W-1:0] first,
                                         logic [POS_W-1:0] last);
    in_item_t it;
    it.operation = op;
    it.element_value = value;
    it.shift_amount = shift;
    it.range_first = first;
    it.range_last = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_query(int unsigned n);
    int unsigned l;
    l = $urandom_range(1, n);
    return make_item(OP_QUERY, $urandom, $urandom, POS_W'(l),
                     POS_W'($urandom_range(l, n)));
  endfunction

  function automatic in_item_t rand_noise();
    logic [OP_W-1:0] op;
    op = OP_W'($urandom_range(0, 3));
    return make_item(op, rand_word(), rand_word(), POS_W'($urandom_range(0, 2047)),
                     POS_W'($urandom_range(0, 2047)));
  endfunction

  // called at a rising edge; returns at the edge where the transfer happened, or after a random gap
  task automatic issue(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    board.note_command(it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // lets rotates with no result finish before anything else happens
  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_count(v);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] cfg_value, int unsigned extra);
    int unsigned n;
    int unsigned pick;
    write_count(cfg_value);
    n = board.ring_len();
    // fill the ring, with a little noise before it is full
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) issue(rand_noise());
      issue(make_item(OP_LOAD, rand_word(), $urandom, POS_W'($urandom),
                      POS_W'($urandom)));
    end
    for (int unsigned i = 0; i < extra; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) issue(rand_query(n));
      else if (pick < 15) issue(make_item(OP_ROTATE, $urandom, rand_word(),
                                          POS_W'($urandom), POS_W'($urandom)));
      else issue(rand_noise());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count still at its reset value, ring empty
    issue(make_item(OP_QUERY, '0, '0, 1, 1024));
    issue(make_item(OP_ROTATE, '0, '1, 0, 0));
    issue(make_item(OP_UNUSED, '1, '1, '1, '1));
    issue(make_item(OP_LOAD, '0, '0, 0, 0));

    // a register value of zero acts as one
    write_count('0);
    issue(make_item(OP_LOAD, '1, '0, 0, 0));
    issue(make_item(OP_LOAD, 32'h1234_5678, '0, 0, 0));
    issue(make_item(OP_QUERY, '0, '0, 1, 1));
    issue(make_item(OP_QUERY, '0, '0, 0, 1));
    issue(make_item(OP_QUERY, '0, '0, 1, 2));
    issue(make_item(OP_ROTATE, '0, '1, 0, 0));
    issue(make_item(OP_QUERY, '0, '0, 1, 1));

    write_count(11'd5);
    issue(make_item(OP_ROTATE, '0, 32'd7, 0, 0));
    issue(make_item(OP_LOAD, '1, '0, 0, 0));
    issue(make_item(OP_LOAD, '0, '0, 0, 0));
    issue(make_item(OP_LOAD, 32'd1, '0, 0, 0));
    issue(make_item(OP_LOAD, 32'h8000_0000, '0, 0, 0));
    issue(make_item(OP_LOAD, 32'h7fff_ffff, '0, 0, 0));
    issue(make_item(OP_QUERY, '0, '0, 1, 5));
    issue(make_item(OP_QUERY, '0, '0, 2, 4));
    issue(make_item(OP_QUERY, '0, '0, 4, 3));
    issue(make_item(OP_QUERY, '0, '0, 2047, 2047));
    issue(make_item(OP_QUERY, '0, '0, 5, 5));
    issue(make_item(OP_ROTATE, '0, 32'd3, 0, 0));
    issue(make_item(OP_QUERY, '0, '0, 1, 1));
    issue(make_item(OP_QUERY, '0, '0, 1024, 1024));

    run_phase(11'd3, 60);
    run_phase(11'd0, 30);
    gaps_on = 1'b0;
    run_phase(11'd12, 60);
    gaps_on = 1'b1;
    run_phase(11'd120, 60);
    run_phase(11'd2, 50);
    run_phase(CFG_W'($urandom_range(1, 64)), 80);
    gaps_on = 1'b0;
    run_phase(11'd1, 30);
    gaps_on = 1'b1;
    run_phase(CFG_W'($urandom_range(1, 64)), 80);

    // a register value above the depth acts as the depth
    write_count(11'd2047);
    issue(make_item(OP_LOAD, 32'd9, '0, 0, 0));
    issue(make_item(OP_QUERY, '0, '0, 1, 1024));
    issue(make_item(OP_QUERY, '0, '0, 1, 1025));

    // closing stretch runs flat out
    gaps_on = 1'b0;
    run_phase(CFG_W'($urandom_range(1, 32)), 100);

    drain();
    if (board.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
